// ===== rtl/core/fbc_pkg.sv =====
// Shared types and constants of the frustum box cull unit.
package fbc_pkg;

  // Coordinate and coefficient word width (Q format, signed)
  localparam int unsigned COORD_W = 32;

  // Opcodes carried in the input tuser
  localparam logic [1:0] OP_LOAD_PLANE = 2'd0;
  localparam logic [1:0] OP_LOAD_POINT = 2'd1;
  localparam logic [1:0] OP_TEST       = 2'd2;

  // Result kinds carried in the output tuser
  localparam logic [1:0] KIND_VISIBLE = 2'd0;
  localparam logic [1:0] KIND_PLANE   = 2'd1;
  localparam logic [1:0] KIND_CORNER  = 2'd2;

  // Table sizes and sequencer limits
  localparam logic [2:0] LAST_PLANE = 3'd5;
  localparam logic [2:0] LAST_POINT = 3'd7;
  localparam logic [1:0] LAST_AXIS  = 2'd2;
  localparam logic [2:0] LAST_TERM  = 3'd5;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic load;   // start a new sum from the plane offset
    logic issue;  // launch one product this cycle
  } mac_ctrl_t;

endpackage

// ===== rtl/core/fbc_mac.sv =====
// Shared MAC unit: one product per cycle while issued, shifted and summed.
module fbc_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbc_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fbc_pkg::COORD_W:0]    op_a_i,
  input  logic signed [fbc_pkg::COORD_W-1:0]  op_b_i,
  input  logic signed [fbc_pkg::COORD_W-1:0]  init_i,
  output logic                                neg_o
);
  import fbc_pkg::*;

  // Full product of a 33-bit and a 32-bit signed operand
  localparam int unsigned PROD_W = 2 * COORD_W + 1;
  // Shifted product plus headroom for the offset and six terms
  localparam int unsigned ACC_W  = PROD_W - FRAC_BITS + 3;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  // Multiply stage
  assign prod_d = op_a_i * op_b_i;

  // Truncate toward minus infinity, then narrow (dropped bits are sign copies)
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign term    = prod_sh[ACC_W-1:0];

  // Add the pending product to the running sum
  assign acc_sum = prod_vld_q ? acc_q + term : acc_q;
  assign acc_d   = ctrl_i.load ? ACC_W'(init_i) : acc_sum;
  assign neg_o   = acc_sum[ACC_W-1];

  // Track whether the product register holds a live term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
    end
  end

  // Hold product and sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

endmodule

// ===== rtl/core/frustum_box_cull_unit.sv =====
// Top level of the frustum box cull unit: tables, sequencer and stream ports.
//
// Tests axis-aligned boxes against six stored frustum planes and eight stored
// frustum corner points, in signed fixed point with FRAC_BITS fraction bits.
// A load transaction (plane or point) writes its table entry directly on
// acceptance; it gives no result. A test transaction runs on one shared
// multiplier: for each plane it issues six products of normal with box
// center and half extent, then does the last accumulate and the sign test,
// and a box rejected at a plane leaves the sequence there. A box that passes
// all planes goes on to the corner test, one point and one axis compared per
// cycle. The done state then moves the result to the output register once
// that register is free. The input is not ready while a test runs; it is
// ready again once the result has been handed to the output register, even
// if that result has not yet been taken. Plane and point tables have no
// reset; every entry must be loaded before a test.
module frustum_box_cull_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input: slot, coef_x, coef_y, coef_z, coef_w, box_min_x, box_min_y,
  //        box_min_z, box_max_x, box_max_y, box_max_z, pad from bit 0 up
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [327:0] s_axis_tdata,
  // Input tuser: opcode
  input  logic [1:0]   s_axis_tuser,
  // Output: visible, reject_index, pad from bit 0 up
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,
  // Output tuser: reject_kind
  output logic [1:0]   m_axis_tuser
);
  import fbc_pkg::*;

  localparam int unsigned SLOT_W = 3;
  localparam int unsigned NUM_IN_WORDS = 10;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_CORN = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  state_e state_d, state_q;
  logic [2:0] plane_idx_d, plane_idx_q;
  logic [2:0] term_d, term_q;
  logic [1:0] axis_d, axis_q;
  logic [2:0] point_idx_d, point_idx_q;
  logic       all_above_d, all_above_q;
  logic       all_below_d, all_below_q;
  logic [1:0] res_kind_d, res_kind_q;
  logic [2:0] res_idx_d, res_idx_q;
  logic       m_valid_d, m_valid_q;
  logic       m_vis_d, m_vis_q;
  logic [1:0] m_kind_d, m_kind_q;
  logic [2:0] m_idx_d, m_idx_q;

  plane_t plane_mem_q [6];
  point_t point_mem_q [8];

  logic signed [COORD_W-1:0] bmin_q [3];
  logic signed [COORD_W-1:0] bmax_q [3];
  logic signed [COORD_W-1:0] ctr_q  [3];
  logic signed [COORD_W-1:0] ext_q  [3];
  logic signed [COORD_W-1:0] ctr_d  [3];
  logic signed [COORD_W-1:0] ext_d  [3];

  logic signed [COORD_W-1:0] in_w [NUM_IN_WORDS];
  logic [1:0]                in_op;
  logic [2:0]                in_slot;
  logic                      in_acc;
  logic                      out_free;

  plane_t                    pl;
  point_t                    pt;
  logic [1:0]                mul_k;
  logic signed [COORD_W-1:0] nrm;
  logic signed [COORD_W:0]   nrm_ext;
  logic signed [COORD_W:0]   nrm_abs;
  logic signed [COORD_W:0]   op_a;
  logic signed [COORD_W-1:0] op_b;
  mac_ctrl_t                 mac_ctrl;
  logic                      acc_neg;
  logic signed [COORD_W-1:0] coord;
  logic                      above, below;
  logic                      cur_above, cur_below;

  // Unpack input transaction
  assign in_op   = s_axis_tuser;
  assign in_slot = s_axis_tdata[SLOT_W-1:0];
  always_comb begin
    for (int i = 0; i < NUM_IN_WORDS; i++) begin
      in_w[i] = s_axis_tdata[SLOT_W + COORD_W*i +: COORD_W];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Box center and half extent, floor of the halved sum and difference
  always_comb begin
    logic signed [COORD_W:0] sum;
    logic signed [COORD_W:0] dif;
    for (int k = 0; k < 3; k++) begin
      sum = {in_w[7+k][COORD_W-1], in_w[7+k]} + {in_w[4+k][COORD_W-1], in_w[4+k]};
      dif = {in_w[7+k][COORD_W-1], in_w[7+k]} - {in_w[4+k][COORD_W-1], in_w[4+k]};
      ctr_d[k] = sum[COORD_W:1];
      ext_d[k] = dif[COORD_W:1];
    end
  end

  // Select multiplier operands: even terms n*center, odd terms extent*|n|
  assign pl    = plane_mem_q[plane_idx_q];
  assign mul_k = term_q[2:1];
  always_comb begin
    case (mul_k)
      2'd0:    nrm = pl.x;
      2'd1:    nrm = pl.y;
      default: nrm = pl.z;
    endcase
  end
  assign nrm_ext = {nrm[COORD_W-1], nrm};
  assign nrm_abs = nrm[COORD_W-1] ? -nrm_ext : nrm_ext;
  assign op_a    = term_q[0] ? nrm_abs : nrm_ext;
  assign op_b    = term_q[0] ? ext_q[mul_k] : ctr_q[mul_k];

  fbc_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .init_i (pl.d),
    .neg_o  (acc_neg)
  );

  // Corner compare: one point, one axis per cycle
  assign pt = point_mem_q[point_idx_q];
  always_comb begin
    case (axis_q)
      2'd0:    coord = pt.x;
      2'd1:    coord = pt.y;
      default: coord = pt.z;
    endcase
  end
  assign above     = coord > bmax_q[axis_q];
  assign below     = coord < bmin_q[axis_q];
  assign cur_above = (point_idx_q == 3'd0) ? above : (all_above_q && above);
  assign cur_below = (point_idx_q == 3'd0) ? below : (all_below_q && below);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    plane_idx_d = plane_idx_q;
    term_d      = term_q;
    axis_d      = axis_q;
    point_idx_d = point_idx_q;
    all_above_d = all_above_q;
    all_below_d = all_below_q;
    res_kind_d  = res_kind_q;
    res_idx_d   = res_idx_q;
    mac_ctrl    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_TEST) begin
          state_d     = ST_MUL;
          plane_idx_d = 3'd0;
          term_d      = 3'd0;
        end
      end
      ST_MUL: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.load  = (term_q == 3'd0);
        term_d         = 3'(term_q + 3'd1);
        if (term_q == LAST_TERM) begin
          term_d  = 3'd0;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_neg) begin
          res_kind_d = KIND_PLANE;
          res_idx_d  = plane_idx_q;
          state_d    = ST_DONE;
        end else if (plane_idx_q == LAST_PLANE) begin
          axis_d      = 2'd0;
          point_idx_d = 3'd0;
          state_d     = ST_CORN;
        end else begin
          plane_idx_d = 3'(plane_idx_q + 3'd1);
          term_d      = 3'd0;
          state_d     = ST_MUL;
        end
      end
      ST_CORN: begin
        all_above_d = cur_above;
        all_below_d = cur_below;
        point_idx_d = 3'(point_idx_q + 3'd1);
        if (point_idx_q == LAST_POINT) begin
          if (cur_above) begin
            res_kind_d = KIND_CORNER;
            res_idx_d  = {axis_q, 1'b0};
            state_d    = ST_DONE;
          end else if (cur_below) begin
            res_kind_d = KIND_CORNER;
            res_idx_d  = {axis_q, 1'b1};
            state_d    = ST_DONE;
          end else if (axis_q == LAST_AXIS) begin
            res_kind_d = KIND_VISIBLE;
            res_idx_d  = 3'd0;
            state_d    = ST_DONE;
          end else begin
            axis_d = 2'(axis_q + 2'd1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load when the slot frees, drop when taken
  always_comb begin
    m_valid_d = m_valid_q;
    m_vis_d   = m_vis_q;
    m_kind_d  = m_kind_q;
    m_idx_d   = m_idx_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (state_q == ST_DONE && out_free) begin
      m_valid_d = 1'b1;
      m_vis_d   = (res_kind_q == KIND_VISIBLE);
      m_kind_d  = res_kind_q;
      m_idx_d   = res_idx_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plane_idx_q <= 3'd0;
      term_q      <= 3'd0;
      axis_q      <= 2'd0;
      point_idx_q <= 3'd0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      plane_idx_q <= plane_idx_d;
      term_q      <= term_d;
      axis_q      <= axis_d;
      point_idx_q <= point_idx_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    all_above_q <= all_above_d;
    all_below_q <= all_below_d;
    res_kind_q  <= res_kind_d;
    res_idx_q   <= res_idx_d;
    m_vis_q     <= m_vis_d;
    m_kind_q    <= m_kind_d;
    m_idx_q     <= m_idx_d;
  end

  // Latch the box of a test transaction
  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == OP_TEST) begin
      for (int k = 0; k < 3; k++) begin
        bmin_q[k] <= in_w[4+k];
        bmax_q[k] <= in_w[7+k];
        ctr_q[k]  <= ctr_d[k];
        ext_q[k]  <= ext_d[k];
      end
    end
  end

  // Write the plane and point tables; drop plane loads beyond the last slot
  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == OP_LOAD_PLANE && in_slot <= LAST_PLANE) begin
      plane_mem_q[in_slot] <= '{d: in_w[3], z: in_w[2], y: in_w[1], x: in_w[0]};
    end
    if (in_acc && in_op == OP_LOAD_POINT) begin
      point_mem_q[in_slot] <= '{z: in_w[2], y: in_w[1], x: in_w[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_idx_q, m_vis_q};
  assign m_axis_tuser  = m_kind_q;

`ifndef SYNTHESIS
  // A test transaction starts the plane sequence on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TEST) |=> state_q == ST_MUL)
    else $error("test transaction did not start the plane sequence");

  // Plane and term counters stay inside the table while the multiplier runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_ACC) |-> (plane_idx_q <= LAST_PLANE &&
                                                  term_q <= LAST_TERM))
    else $error("plane sequencer out of range");

  // The accumulate step always follows the last product of a plane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && term_q == LAST_TERM) |=> state_q == ST_ACC)
    else $error("accumulate step skipped");

  // Visible flag, kind and index agree on every result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((m_vis_q == (m_kind_q == KIND_VISIBLE)) &&
                   (m_kind_q != KIND_VISIBLE || m_idx_q == 3'd0) &&
                   m_idx_q <= LAST_PLANE))
    else $error("inconsistent result fields");
`endif

endmodule
